FILE: hdl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg - shared types and constants for the HTTP request head parser
// Parser phases, token and event codes, character constants, class helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

    // Width of the internal byte position counter (8 to 32)
    localparam int OFFSET_BITS = 16;

    // Parser phase
    typedef enum logic [4:0] {
        P_LEAD   = 5'd0,
        P_METHOD = 5'd1,
        P_USKIP  = 5'd2,
        P_URI    = 5'd3,
        P_URICR  = 5'd4,
        P_AFTURI = 5'd5,
        P_H1     = 5'd6,
        P_H2     = 5'd7,
        P_H3     = 5'd8,
        P_H4     = 5'd9,
        P_VER    = 5'd10,
        P_VERBL  = 5'd11,
        P_SLCR   = 5'd12,
        P_HSTART = 5'd13,
        P_HENDCR = 5'd14,
        P_HLEAD  = 5'd15,
        P_KEY    = 5'd16,
        P_KEYBL  = 5'd17,
        P_COLON  = 5'd18,
        P_VAL    = 5'd19,
        P_VALCR  = 5'd20,
        P_DONE   = 5'd21,
        P_ERR    = 5'd22
    } phase_t;

    // Token kind of a byte
    typedef enum logic [2:0] {
        TK_NONE = 3'd0,
        TK_METH = 3'd1,
        TK_URI  = 3'd2,
        TK_VER  = 3'd3,
        TK_KEY  = 3'd4,
        TK_VAL  = 3'd5
    } token_t;

    // Event reported with a byte
    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_SL   = 3'd1,
        EV_HL   = 3'd2,
        EV_HEAD = 3'd3,
        EV_BAD  = 3'd4
    } event_t;

    // Result of one parser step
    typedef struct packed {
        phase_t     phase;
        logic       nonempty;
        token_t     token;
        event_t     evt;
    } step_res_t;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_keych(input logic [7:0] b);
        return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ))
            || (b == CH_DASH);
    endfunction

    function automatic logic is_verch(input logic [7:0] b);
        return ((b >= CH_0) && (b <= CH_9)) || (b == CH_DOT);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hrhp_step.sv
// ----------------------------------------------------------------------------
// hrhp_step - one byte of the request head parser state machine
// Given the current phase and a byte, gives next phase, token kind and event.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_step
    import hrhp_pkg::*;
(
    input  var phase_t     phase,
    input  wire            nonempty,
    input  wire  [7:0]     data_byte,
    input  wire            first,
    output step_res_t      res
);

    phase_t     cur;
    logic       ne_cur;
    phase_t     np;
    logic       ne_n;
    token_t     tk;
    event_t     ev;
    logic [7:0] b;

    // A flagged first byte restarts from the top of the start line
    assign cur    = first ? P_LEAD : phase;
    assign ne_cur = first ? 1'b0 : nonempty;
    assign b      = data_byte;

    // Next phase and classification
    always_comb
    begin
        np   = P_ERR;
        ne_n = ne_cur;
        tk   = TK_NONE;
        ev   = EV_NONE;
        unique case (cur)
            P_LEAD:
            begin
                if (b == CH_CR || b == CH_LF) np = P_LEAD;
                else if (is_keych(b)) begin tk = TK_METH; np = P_METHOD; end
            end
            P_METHOD:
            begin
                if (is_keych(b)) begin tk = TK_METH; np = P_METHOD; end
                else if (is_blank(b)) np = P_USKIP;
            end
            P_USKIP:
            begin
                if (is_blank(b)) np = P_USKIP;
                else if (b == CH_CR) np = P_URICR;
                else begin tk = TK_URI; np = P_URI; end
            end
            P_URI:
            begin
                if (is_blank(b)) np = P_AFTURI;
                else if (b == CH_CR) np = P_URICR;
                else begin tk = TK_URI; np = P_URI; end
            end
            P_URICR, P_SLCR:
            begin
                if (b == CH_LF) begin ev = EV_SL; np = P_HSTART; end
            end
            P_AFTURI:
            begin
                if (is_blank(b)) np = P_AFTURI;
                else if (b == CH_CR) np = P_SLCR;
                else if (b == CH_H) np = P_H1;
            end
            P_H1: if (b == CH_T) np = P_H2;
            P_H2: if (b == CH_T) np = P_H3;
            P_H3: if (b == CH_P) np = P_H4;
            P_H4:
            begin
                if (b == CH_SLASH) begin ne_n = 1'b0; np = P_VER; end
            end
            P_VER:
            begin
                if (is_verch(b)) begin tk = TK_VER; ne_n = 1'b1; np = P_VER; end
                else if (ne_cur && is_blank(b)) np = P_VERBL;
                else if (ne_cur && b == CH_CR) np = P_SLCR;
            end
            P_VERBL:
            begin
                if (is_blank(b)) np = P_VERBL;
                else if (b == CH_CR) np = P_SLCR;
            end
            P_HSTART:
            begin
                if (b == CH_CR) np = P_HENDCR;
                else if (is_blank(b)) np = P_HLEAD;
                else if (is_keych(b)) begin tk = TK_KEY; np = P_KEY; end
            end
            P_HENDCR:
            begin
                if (b == CH_LF) begin ev = EV_HEAD; np = P_DONE; end
            end
            P_HLEAD:
            begin
                if (is_blank(b)) np = P_HLEAD;
                else if (is_keych(b)) begin tk = TK_KEY; np = P_KEY; end
            end
            P_KEY:
            begin
                if (is_keych(b)) begin tk = TK_KEY; np = P_KEY; end
                else if (is_blank(b)) np = P_KEYBL;
                else if (b == CH_COLON) np = P_COLON;
            end
            P_KEYBL:
            begin
                if (is_blank(b)) np = P_KEYBL;
                else if (b == CH_COLON) np = P_COLON;
            end
            P_COLON:
            begin
                if (is_blank(b)) np = P_COLON;
                else if (b != CH_CR && b != CH_LF && b != CH_NUL)
                begin
                    tk = TK_VAL;
                    np = P_VAL;
                end
            end
            P_VAL:
            begin
                if (b == CH_CR) np = P_VALCR;
                else if (b != CH_LF && b != CH_NUL) begin tk = TK_VAL; np = P_VAL; end
            end
            P_VALCR:
            begin
                if (b == CH_LF) begin ev = EV_HL; np = P_HSTART; end
            end
            P_DONE:
            begin
                ev = EV_HEAD;
                np = P_DONE;
            end
            default:
            begin
                np = P_ERR;
            end
        endcase
        // Any error, including staying in the error phase
        if (np == P_ERR)
        begin
            tk = TK_NONE;
            ev = EV_BAD;
        end
    end

    // Outputs
    always_comb
    begin
        res.phase    = np;
        res.nonempty = ne_n;
        res.token    = tk;
        res.evt      = ev;
    end

endmodule

`default_nettype wire

FILE: hdl/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// http_request_head_parser - byte-serial HTTP/1.1 request head parser
// Classifies each byte of a request head and flags line and head boundaries.
// ----------------------------------------------------------------------------
// Takes one byte per clock on the input channel while in_ready is high and
// returns one result per byte (offset, token kind, event) on the output
// channel, in order. An accepted byte is registered in the input register,
// stepped through the parser state machine into the result register and
// presented on the output from there. The sustained rate is one byte per
// cycle while out_ready is high, set by the loop through the phase register.
// The input register moves into the result register whenever the result is
// taken or empty, so stalls on the output side propagate back to in_ready;
// with both registers full and out_ready low, in_ready drops. An error or end
// of head is held until a byte with first set begins a new message; the offset saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_head_parser
    import hrhp_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [7:0]  data_byte,
    input  wire         first,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [15:0] offset,
    output logic [2:0]  token_kind,
    output logic [2:0]  event_res
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    // Input stage
    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_first_reg;

    // Parser state
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic                   nonempty_reg;
    logic                   nonempty_next;
    logic [OFFSET_BITS-1:0] position_reg;
    logic [OFFSET_BITS-1:0] position_next;
    logic [OFFSET_BITS-1:0] pos_cur;

    // Result stage
    logic                   out_valid_reg;
    logic [15:0]            offset_reg;
    logic [15:0]            offset_next;
    token_t                 token_reg;
    event_t                 event_reg;

    logic                   s1_adv;
    step_res_t              step;
    logic [OFFSET_BITS+15:0] pos_ext;

    // Flow control: stage 1 moves when the result slot is free or being taken
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    hrhp_step u_step (
        .phase     (phase_reg),
        .nonempty  (nonempty_reg),
        .data_byte (s1_byte_reg),
        .first     (s1_first_reg),
        .res       (step)
    );

    // Position of this byte, and of the next one
    always_comb
    begin
        pos_cur       = s1_first_reg ? '0 : position_reg;
        position_next = (pos_cur == POS_MAX) ? POS_MAX : pos_cur + OFFSET_BITS'(1);
        pos_ext       = {16'd0, pos_cur};
        offset_next   = pos_ext[15:0];
        phase_next    = step.phase;
        nonempty_next = step.nonempty;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= data_byte;
            s1_first_reg <= first;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= P_LEAD;
            nonempty_reg <= 1'b0;
            position_reg <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg    <= phase_next;
            nonempty_reg <= nonempty_next;
            position_reg <= position_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            offset_reg <= offset_next;
            token_reg  <= step.token;
            event_reg  <= step.evt;
        end
    end

    assign out_valid  = out_valid_reg;
    assign offset     = offset_reg;
    assign token_kind = token_reg;
    assign event_res  = event_reg;

`ifndef SYNTHESIS
    // A malformed byte never carries a token
    a_bad_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_BAD) |-> (token_kind == TK_NONE))
        else $error("malformed byte reported with a token");

    // End of head is sticky until a new message
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_first_reg && phase_reg == P_DONE) |=> (event_res == EV_HEAD))
        else $error("end of head not held");

    // Error is sticky until a new message
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_first_reg && phase_reg == P_ERR) |=> (event_res == EV_BAD))
        else $error("error not held");

    // First byte of a message is at offset zero
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_first_reg) |=> (offset == 16'd0))
        else $error("first byte not at offset zero");

    // Empty input register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled while empty");
`endif

endmodule

`default_nettype wire
